// File: hw/rtl/swam_pkg.sv
package swam_pkg;

  localparam int unsigned ALPHABET   = 26;
  localparam int unsigned MAX_WINDOW = 256;

  localparam int unsigned SYM_W = 5;
  localparam int unsigned LTR_W = $clog2(ALPHABET);
  localparam int unsigned PTR_W = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CNT_W = 10;
  localparam int unsigned MM_W  = 5;
  localparam int unsigned POS_W = 32;
  localparam int unsigned OP_W  = 2;

  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_PATTERN = 2'd1;
  localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CLEAR,
    KIND_PATTERN,
    KIND_TEXT
  } kind_e;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [SYM_W-1:0] sym;
    logic             drop;
    logic             check;
    logic [POS_W-1:0] pos;
  } stage_t;

endpackage

// File: hw/rtl/swam_if.sv
interface swam_in_if;
  logic                       valid;
  logic                       ready;
  logic [swam_pkg::OP_W-1:0]  op;
  logic [swam_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output op, output symbol, input ready);
  modport sink (input valid, input op, input symbol, output ready);
endinterface

interface swam_out_if;
  logic                       valid;
  logic                       ready;
  logic [swam_pkg::POS_W-1:0] start_position;

  modport source (output valid, output start_position, input ready);
  modport sink (input valid, input start_position, output ready);
endinterface

// File: hw/rtl/sliding_window_anagram_matcher.sv
// Sliding-window anagram search over a stream of letters 0..25.
// in_i carries op (clear, pattern letter, text letter) and symbol; out_o
// carries start_position, the text index where a matching window begins.
// Load the pattern first, then stream text; clear before a new pattern.
// One item is taken per cycle while ready is high. Results pass the front
// and count stage registers and the result buffer. The rate is set by the
// window ring, which swaps the leaving letter for the entering one in the
// same cycle, and by two count memories, each written at most once per item.
// Updates to the same letter in consecutive items are forwarded from the
// last write, so repeated letters do not slow the stream.
// Reset, and a clear item, empty all counts at once through per-letter
// valid bits; there is no clearing pass.
// Results queue in a four-entry buffer. When out_o stalls, in_i keeps
// taking items until the buffer plus items in flight would fill it, then
// drops ready until a result is taken or an item leaves with no result.
module sliding_window_anagram_matcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  swam_in_if.sink    in_i,
  swam_out_if.source out_o
);

  swam_pkg::stage_t               s1;
  logic [swam_pkg::SYM_W-1:0]     old_sym;
  logic                           s2_busy;
  logic                           res_valid;
  logic [swam_pkg::POS_W-1:0]     res_pos;
  logic [swam_pkg::OUT_CNT_W-1:0] fifo_cnt;
  logic [swam_pkg::OUT_CNT_W:0]   pending;
  logic                           accept;

  // reserve a buffer slot for every item still in the pipeline
  assign pending = (swam_pkg::OUT_CNT_W + 1)'(fifo_cnt)
                 + (swam_pkg::OUT_CNT_W + 1)'(s1.valid)
                 + (swam_pkg::OUT_CNT_W + 1)'(s2_busy);
  assign in_i.ready = pending < (swam_pkg::OUT_CNT_W + 1)'(swam_pkg::OUT_DEPTH);
  assign accept     = in_i.valid && in_i.ready;

  swam_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (in_i.op),
    .symbol_i  (in_i.symbol),
    .stage_o   (s1),
    .old_sym_o (old_sym)
  );

  swam_count u_count (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_i        (s1),
    .old_sym_i      (old_sym),
    .busy_o         (s2_busy),
    .result_valid_o (res_valid),
    .result_pos_o   (res_pos)
  );

  swam_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_pos),
    .count_o (fifo_cnt),
    .out_o   (out_o)
  );

endmodule

// File: hw/rtl/swam_front.sv
module swam_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [swam_pkg::OP_W-1:0]   op_i,
  input  logic [swam_pkg::SYM_W-1:0]  symbol_i,
  output swam_pkg::stage_t            stage_o,
  output logic [swam_pkg::SYM_W-1:0]  old_sym_o
);

  logic [swam_pkg::LEN_W-1:0] wl_q, wl_d;
  logic [swam_pkg::POS_W-1:0] ts_q, ts_d;
  logic [swam_pkg::PTR_W-1:0] ptr_q, ptr_d;
  swam_pkg::stage_t           st_q, st_d;
  logic                       ring_we;
  logic                       sym_ok;
  logic [swam_pkg::POS_W-1:0] wl_ext;
  logic [swam_pkg::POS_W-1:0] ts_new;
  logic [swam_pkg::LEN_W-1:0] ptr_inc;

  logic [swam_pkg::SYM_W-1:0] ring_q [swam_pkg::MAX_WINDOW];
  logic [swam_pkg::SYM_W-1:0] old_q;

  assign sym_ok  = symbol_i < swam_pkg::SYM_W'(swam_pkg::ALPHABET);
  assign wl_ext  = swam_pkg::POS_W'(wl_q);
  assign ts_new  = (ts_q == '1) ? ts_q : ts_q + 1'b1;
  assign ptr_inc = swam_pkg::LEN_W'(ptr_q) + 1'b1;

  always_comb begin
    wl_d     = wl_q;
    ts_d     = ts_q;
    ptr_d    = ptr_q;
    ring_we  = 1'b0;
    st_d     = '0;
    st_d.kind = swam_pkg::KIND_NONE;
    if (accept_i) begin
      st_d.valid = 1'b1;
      st_d.sym   = symbol_i;
      unique case (op_i)
        swam_pkg::OP_CLEAR: begin
          st_d.kind = swam_pkg::KIND_CLEAR;
          wl_d      = '0;
          ts_d      = '0;
          ptr_d     = '0;
        end
        swam_pkg::OP_PATTERN: begin
          if (sym_ok && wl_q < swam_pkg::LEN_W'(swam_pkg::MAX_WINDOW) && ts_q == '0) begin
            st_d.kind = swam_pkg::KIND_PATTERN;
            wl_d      = wl_q + 1'b1;
          end
        end
        swam_pkg::OP_TEXT: begin
          if (sym_ok && wl_q != '0) begin
            st_d.kind  = swam_pkg::KIND_TEXT;
            st_d.drop  = ts_q >= wl_ext;
            st_d.check = ts_new >= wl_ext;
            st_d.pos   = ts_new - wl_ext;
            ts_d       = ts_new;
            ring_we    = 1'b1;
            // wrap the slot pointer at the window length
            ptr_d      = (ptr_inc == wl_q) ? '0 : ptr_inc[swam_pkg::PTR_W-1:0];
          end
        end
        default: begin
          st_d.kind = swam_pkg::KIND_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q  <= '0;
      ts_q  <= '0;
      ptr_q <= '0;
      st_q  <= '0;
    end else begin
      wl_q  <= wl_d;
      ts_q  <= ts_d;
      ptr_q <= ptr_d;
      st_q  <= st_d;
    end
  end

  // read the leaving letter and write the entering one at the same slot
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[ptr_q] <= symbol_i;
      old_q         <= ring_q[ptr_q];
    end
  end

  assign stage_o   = st_q;
  assign old_sym_o = old_q;

endmodule

// File: hw/rtl/swam_count.sv
module swam_count (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swam_pkg::stage_t            stage_i,
  input  logic [swam_pkg::SYM_W-1:0]  old_sym_i,
  output logic                        busy_o,
  output logic                        result_valid_o,
  output logic [swam_pkg::POS_W-1:0]  result_pos_o
);

  // Difference of a letter is entered count minus (left + pattern) count,
  // both kept modulo 2^CNT_W in two memories with one write port each.
  logic [swam_pkg::CNT_W-1:0] mem_a [swam_pkg::ALPHABET];
  logic [swam_pkg::CNT_W-1:0] mem_b [swam_pkg::ALPHABET];

  logic [swam_pkg::LTR_W-1:0] rd_sym, rd_old;
  logic [swam_pkg::CNT_W-1:0] a_s_q, a_o_q, b_s_q, b_o_q;

  swam_pkg::stage_t           s2_q;
  logic [swam_pkg::LTR_W-1:0] s2_old_q;
  logic [swam_pkg::LTR_W-1:0] s2_sym;

  logic [swam_pkg::ALPHABET-1:0] vld_a_q, vld_a_d, vld_b_q, vld_b_d;

  logic                       fa_v_q, fa_v_d, fb_v_q, fb_v_d;
  logic [swam_pkg::LTR_W-1:0] fa_addr_q, fb_addr_q;
  logic [swam_pkg::CNT_W-1:0] fa_data_q, fb_data_q;

  logic [swam_pkg::MM_W-1:0]  mm_q, mm_d;

  logic [swam_pkg::CNT_W-1:0] a_s, a_o, b_s, b_o;
  logic [swam_pkg::CNT_W-1:0] diff_s, diff_o, new_s, new_o;
  logic                       we_a, we_b;
  logic [swam_pkg::LTR_W-1:0] wa_addr, wb_addr;
  logic [swam_pkg::CNT_W-1:0] wa_data, wb_data;
  logic                       is_text, is_pat, is_clear, same, use_o;
  logic                       s_up, s_dn, o_up, o_dn;

  assign rd_sym = stage_i.sym[swam_pkg::LTR_W-1:0];
  assign rd_old = stage_i.drop ? old_sym_i[swam_pkg::LTR_W-1:0] : '0;
  assign s2_sym = s2_q.sym[swam_pkg::LTR_W-1:0];

  // take the last write when it went to the same letter
  assign a_s = (fa_v_q && fa_addr_q == s2_sym)   ? fa_data_q :
               (vld_a_q[s2_sym] ? a_s_q : '0);
  assign a_o = (fa_v_q && fa_addr_q == s2_old_q) ? fa_data_q :
               (vld_a_q[s2_old_q] ? a_o_q : '0);
  assign b_s = (fb_v_q && fb_addr_q == s2_sym)   ? fb_data_q :
               (vld_b_q[s2_sym] ? b_s_q : '0);
  assign b_o = (fb_v_q && fb_addr_q == s2_old_q) ? fb_data_q :
               (vld_b_q[s2_old_q] ? b_o_q : '0);

  assign is_text  = s2_q.valid && s2_q.kind == swam_pkg::KIND_TEXT;
  assign is_pat   = s2_q.valid && s2_q.kind == swam_pkg::KIND_PATTERN;
  assign is_clear = s2_q.valid && s2_q.kind == swam_pkg::KIND_CLEAR;
  assign same     = s2_q.drop && s2_old_q == s2_sym;
  assign use_o    = is_text && s2_q.drop && !same;

  assign diff_s = a_s - b_s;
  assign diff_o = a_o - b_o;
  assign new_s  = is_pat ? diff_s - 1'b1 : diff_s + 1'b1;
  assign new_o  = diff_o - 1'b1;

  assign s_up = (is_pat || (is_text && !same)) && diff_s == '0 && new_s != '0;
  assign s_dn = (is_pat || (is_text && !same)) && diff_s != '0 && new_s == '0;
  assign o_up = use_o && diff_o == '0 && new_o != '0;
  assign o_dn = use_o && diff_o != '0 && new_o == '0;

  always_comb begin
    we_a    = is_text;
    wa_addr = s2_sym;
    wa_data = a_s + 1'b1;
    we_b    = is_pat || (is_text && s2_q.drop);
    wb_addr = is_pat ? s2_sym : s2_old_q;
    wb_data = is_pat ? b_s + 1'b1 : b_o + 1'b1;

    vld_a_d = vld_a_q;
    vld_b_d = vld_b_q;
    fa_v_d  = we_a;
    fb_v_d  = we_b;
    mm_d    = mm_q + swam_pkg::MM_W'(s_up) + swam_pkg::MM_W'(o_up)
                   - swam_pkg::MM_W'(s_dn) - swam_pkg::MM_W'(o_dn);
    if (we_a) vld_a_d[wa_addr] = 1'b1;
    if (we_b) vld_b_d[wb_addr] = 1'b1;
    if (is_clear) begin
      vld_a_d = '0;
      vld_b_d = '0;
      fa_v_d  = 1'b0;
      fb_v_d  = 1'b0;
      mm_d    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[wa_addr] <= wa_data;
    if (we_b) mem_b[wb_addr] <= wb_data;
    a_s_q <= mem_a[rd_sym];
    a_o_q <= mem_a[rd_old];
    b_s_q <= mem_b[rd_sym];
    b_o_q <= mem_b[rd_old];
    s2_old_q  <= rd_old;
    fa_addr_q <= wa_addr;
    fa_data_q <= wa_data;
    fb_addr_q <= wb_addr;
    fb_data_q <= wb_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q    <= '0;
      vld_a_q <= '0;
      vld_b_q <= '0;
      fa_v_q  <= 1'b0;
      fb_v_q  <= 1'b0;
      mm_q    <= '0;
    end else begin
      s2_q    <= stage_i;
      vld_a_q <= vld_a_d;
      vld_b_q <= vld_b_d;
      fa_v_q  <= fa_v_d;
      fb_v_q  <= fb_v_d;
      mm_q    <= mm_d;
    end
  end

  assign busy_o         = s2_q.valid;
  assign result_valid_o = is_text && s2_q.check && mm_d == '0;
  assign result_pos_o   = s2_q.pos;

endmodule

// File: hw/rtl/swam_out_fifo.sv
module swam_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [swam_pkg::POS_W-1:0]     data_i,
  output logic [swam_pkg::OUT_CNT_W-1:0] count_o,
  swam_out_if.source                     out_o
);

  logic [swam_pkg::POS_W-1:0]     fifo_q [swam_pkg::OUT_DEPTH];
  logic [swam_pkg::OUT_PTR_W-1:0] wr_q, rd_q;
  logic [swam_pkg::OUT_CNT_W-1:0] cnt_q;
  logic                           pop;

  assign pop                  = out_o.valid && out_o.ready;
  assign out_o.valid          = cnt_q != '0;
  assign out_o.start_position = fifo_q[rd_q];
  assign count_o              = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) fifo_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + swam_pkg::OUT_CNT_W'(push_i) - swam_pkg::OUT_CNT_W'(pop);
    end
  end

endmodule

// File: dv/testbench.sv
module testbench;

  localparam logic [swam_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned SYM_MAX = (1 << swam_pkg::SYM_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int ITEM_TARGET = 600;

  logic clk_i;
  logic rst_ni;

  swam_in_if  in_if ();
  swam_out_if out_if ();

  sliding_window_anagram_matcher uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predicted state of the matcher
  int                         diff_count[swam_pkg::ALPHABET];
  int                         letters_off;
  int unsigned                win_len;
  logic [swam_pkg::POS_W-1:0] text_count;
  logic [swam_pkg::SYM_W-1:0] ring_mem[swam_pkg::MAX_WINDOW];
  int unsigned                ring_slot;

  logic [swam_pkg::POS_W-1:0] match_starts[$];
  logic [swam_pkg::POS_W-1:0] expected_start;
  int                         items_sent;
  int                         burst_left;
  int                         fail_count;
  int unsigned                cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic void clear_matcher_model();
    foreach (diff_count[i]) diff_count[i] = 0;
    letters_off = 0;
    win_len = 0;
    text_count = '0;
    ring_slot = 0;
  endfunction

  function automatic void bump_letter(input logic [swam_pkg::SYM_W-1:0] letter,
                                      input int delta);
    bit was_off;
    bit now_off;
    was_off = diff_count[letter] != 0;
    diff_count[letter] += delta;
    now_off = diff_count[letter] != 0;
    if (was_off && !now_off) letters_off--;
    else if (!was_off && now_off) letters_off++;
  endfunction

  function automatic void predict_match(input logic [swam_pkg::OP_W-1:0] op,
                                        input logic [swam_pkg::SYM_W-1:0] sym);
    case (op)
      swam_pkg::OP_CLEAR: begin
        clear_matcher_model();
      end
      swam_pkg::OP_PATTERN: begin
        if (sym < swam_pkg::ALPHABET && win_len < swam_pkg::MAX_WINDOW
            && text_count == 0) begin
          bump_letter(sym, -1);
          win_len++;
        end
      end
      swam_pkg::OP_TEXT: begin
        if (sym < swam_pkg::ALPHABET && win_len != 0) begin
          if (ring_slot >= win_len) ring_slot = 0;
          // drop the letter leaving a full window
          if (text_count >= win_len) bump_letter(ring_mem[ring_slot], -1);
          bump_letter(sym, 1);
          ring_mem[ring_slot] = sym;
          ring_slot++;
          if (ring_slot >= win_len) ring_slot = 0;
          if (text_count != '1) text_count++;
          if (text_count >= win_len && letters_off == 0) begin
            match_starts.push_back(text_count - win_len);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [swam_pkg::OP_W-1:0] op, input int unsigned sym);
    int gap;
    logic [swam_pkg::SYM_W-1:0] sym_bits;
    sym_bits = swam_pkg::SYM_W'(sym);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
    end
    in_if.valid  <= 1'b1;
    in_if.op     <= op;
    in_if.symbol <= sym_bits;
    do @(posedge clk_i); while (!in_if.ready);
    predict_match(op, sym_bits);
    items_sent++;
    @(negedge clk_i);
    burst_left--;
  endtask

  // Receiver stalls on a rotating mask that is redrawn after each random hold
  initial begin
    logic [7:0] stall_mask;
    int hold;
    out_if.ready = 1'b0;
    forever begin
      hold = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: stall_mask = 8'hFF;
        1: stall_mask = 8'($urandom) | 8'h01;
        2: stall_mask = 8'h01;
        default: stall_mask = 8'hEE;
      endcase
      repeat (hold) begin
        @(negedge clk_i);
        out_if.ready <= stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[7:1]};
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (match_starts.size() == 0) begin
        $error("start_position: expected none, actual %0d", out_if.start_position);
        fail_count++;
      end else begin
        expected_start = match_starts.pop_front();
        if (out_if.start_position !== expected_start) begin
          $error("start_position: expected %0d, actual %0d",
                 expected_start, out_if.start_position);
          fail_count++;
        end
      end
    end
  end

  task automatic test_special_cases();
    send_item(swam_pkg::OP_CLEAR, SYM_MAX);
    send_item(swam_pkg::OP_TEXT, 2);            // no pattern yet: ignored
    send_item(swam_pkg::OP_PATTERN, 0);
    send_item(swam_pkg::OP_PATTERN, 25);
    send_item(swam_pkg::OP_PATTERN, 0);
    send_item(swam_pkg::OP_PATTERN, SYM_MAX);   // out of range
    send_item(OP_UNUSED, 0);
    send_item(swam_pkg::OP_TEXT, 25);
    send_item(swam_pkg::OP_TEXT, 0);
    send_item(swam_pkg::OP_TEXT, 0);
    send_item(swam_pkg::OP_TEXT, 0);
    send_item(swam_pkg::OP_TEXT, 25);
    send_item(swam_pkg::OP_TEXT, swam_pkg::ALPHABET);     // out of range
    send_item(swam_pkg::OP_PATTERN, 1);         // text already flowing: ignored
    send_item(OP_UNUSED, SYM_MAX);
    send_item(swam_pkg::OP_TEXT, 0);
    send_item(swam_pkg::OP_TEXT, 16);
    send_item(swam_pkg::OP_CLEAR, 0);
    send_item(swam_pkg::OP_PATTERN, 16);
    send_item(swam_pkg::OP_TEXT, 16);
    send_item(swam_pkg::OP_TEXT, 15);
    send_item(swam_pkg::OP_TEXT, 16);
    send_item(swam_pkg::OP_CLEAR, 7);
  endtask

  task automatic test_full_window();
    int unsigned window_letters[swam_pkg::MAX_WINDOW];
    int unsigned swap_letter;
    int j;
    send_item(swam_pkg::OP_CLEAR, 0);
    for (int i = 0; i < swam_pkg::MAX_WINDOW; i++) begin
      window_letters[i] = $urandom_range(0, swam_pkg::ALPHABET - 1);
      send_item(swam_pkg::OP_PATTERN, window_letters[i]);
    end
    // beyond capacity: ignored
    repeat (3) send_item(swam_pkg::OP_PATTERN, $urandom_range(0, swam_pkg::ALPHABET - 1));
    for (int i = swam_pkg::MAX_WINDOW - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap_letter = window_letters[i];
      window_letters[i] = window_letters[j];
      window_letters[j] = swap_letter;
    end
    for (int i = 0; i < swam_pkg::MAX_WINDOW; i++) begin
      send_item(swam_pkg::OP_TEXT, window_letters[i]);
    end
    // repeat the leaving letter so every later window still matches
    for (int i = 0; i < 16; i++) send_item(swam_pkg::OP_TEXT, window_letters[i]);
  endtask

  task automatic test_random_streams();
    int plen;
    int span;
    int base;
    int tlen;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) != 0) send_item(swam_pkg::OP_CLEAR, $urandom);
      span = $urandom_range(1, 4);
      base = $urandom_range(0, swam_pkg::ALPHABET - span);
      case ($urandom_range(0, 15))
        0: plen = 0;
        1: plen = $urandom_range(13, 40);
        default: plen = $urandom_range(1, 6);
      endcase
      repeat (plen) send_item(swam_pkg::OP_PATTERN, base + $urandom_range(0, span - 1));
      tlen = $urandom_range(0, 32);
      repeat (tlen) begin
        case ($urandom_range(0, 19))
          0: send_item(OP_UNUSED, $urandom);
          1: send_item(swam_pkg::OP_TEXT, $urandom_range(swam_pkg::ALPHABET, SYM_MAX));
          2: send_item(swam_pkg::OP_PATTERN, $urandom_range(0, swam_pkg::ALPHABET - 1));
          3: send_item(swam_pkg::OP_TEXT, $urandom_range(0, swam_pkg::ALPHABET - 1));
          4: send_item(swam_pkg::OP_PATTERN, $urandom_range(swam_pkg::ALPHABET, SYM_MAX));
          default: send_item(swam_pkg::OP_TEXT, base + $urandom_range(0, span - 1));
        endcase
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = swam_pkg::OP_CLEAR;
    in_if.symbol = '0;
    fail_count = 0;
    items_sent = 0;
    burst_left = 0;
    clear_matcher_model();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_special_cases();
    test_full_window();
    test_random_streams();
    in_if.valid <= 1'b0;

    while (match_starts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/swam_pkg.sv
hw/rtl/swam_if.sv
hw/rtl/swam_front.sv
hw/rtl/swam_count.sv
hw/rtl/swam_out_fifo.sv
hw/rtl/sliding_window_anagram_matcher.sv
dv/testbench.sv
